### src/gdt_pkg.sv
// gdt_pkg: shared types and constants of the glitch-hardened delay timer
// no dependencies; used by glitch_hardened_delay_timer
`timescale 1ns / 1ps

package gdt_pkg;

  // tolerance multiplier on the software budget
  localparam int unsigned TOLERANCE_MULT = 8;

  // hardware tick deltas above this count as a stale sample
  localparam logic [31:0] DELTA_MAX   = 32'd1000;
  // slack added to the scaled target before a timing fault
  localparam logic [31:0] LIMIT_SLACK = 32'd1001;
  // longest sleep requested in one iteration
  localparam logic [31:0] SLEEP_MAX   = 32'd50;
  // scale factor as a 32-bit operand
  localparam logic [31:0] LIMIT_MULT  = 32'(TOLERANCE_MULT);
  // largest delay that keeps target*mult+slack inside 32 bits
  localparam logic [31:0] WAIT_CAP    =
    32'((64'hFFFF_FFFF - 64'd1001) / TOLERANCE_MULT);

  // input word kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_STARTED = 3'd0;
  localparam logic [2:0] ST_SLEEP   = 3'd1;
  localparam logic [2:0] ST_DONE    = 3'd2;
  localparam logic [2:0] ST_TIMING  = 3'd3;
  localparam logic [2:0] ST_GLITCH  = 3'd4;
  localparam logic [2:0] ST_IGNORED = 3'd5;

  // timer phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_RUN  = 3'b010,
    PH_HALT = 3'b100
  } phase_t;

  // input word
  typedef struct packed {
    logic        kind;
    logic [31:0] wait_ms;
    logic [31:0] tick_now;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] sleep_ms;
    logic       kick_watchdog;
  } out_word_t;

endpackage

### src/glitch_hardened_delay_timer.sv
// glitch_hardened_delay_timer: delay loop with redundant software accounting
// depends on gdt_pkg
`timescale 1ns / 1ps

// Glitch-hardened delay timer. A start word loads a delay (capped so that
// delay*TOLERANCE_MULT+1001 fits in 32 bits) and the current tick, or reports
// done if the delay is zero; each tick word while running kicks the watchdog,
// accumulates the hardware tick delta and either reports done, a timing fault,
// a glitch fault or a sleep request of up to 50 ms. A fault halts the timer until
// reset; every word gives one result. Each word is decided in the cycle it is
// accepted, so one word per cycle is taken while the skid register is empty;
// a two-entry buffer (result plus skid register) absorbs a stalled result side.
module glitch_hardened_delay_timer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gdt_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gdt_pkg::out_word_t out_data
);

  // state
  gdt_pkg::phase_t    phase_r, phase_nxt;
  logic [31:0]        target_r, target_nxt;
  logic [31:0]        prev_tick_r, prev_tick_nxt;
  logic [31:0]        hw_elapsed_r, hw_elapsed_nxt;
  logic [31:0]        sw_total_r, sw_total_nxt;
  logic [31:0]        sw_inv_r, sw_inv_nxt;
  logic [31:0]        sw_limit_r, sw_limit_nxt;

  // output buffer
  logic               out_valid_r, skid_valid_r;
  gdt_pkg::out_word_t out_r, skid_r;
  gdt_pkg::out_word_t res;

  logic               acc;
  logic [31:0]        tgt_capped;
  logic [31:0]        delta;
  logic [31:0]        hw_sum;
  logic [31:0]        remaining;
  logic [31:0]        step;
  logic [31:0]        sw_sum;
  logic [31:0]        inv_diff;

  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // datapath terms
  assign tgt_capped = (in_data.wait_ms > gdt_pkg::WAIT_CAP) ? gdt_pkg::WAIT_CAP
                                                            : in_data.wait_ms;
  assign delta      = ((in_data.tick_now - prev_tick_r) > gdt_pkg::DELTA_MAX) ? 32'd0
                      : (in_data.tick_now - prev_tick_r);
  assign hw_sum     = hw_elapsed_r + delta;
  assign remaining  = (target_r > sw_total_r) ? (target_r - sw_total_r) : 32'd1;
  assign step       = (remaining > gdt_pkg::SLEEP_MAX) ? gdt_pkg::SLEEP_MAX : remaining;
  assign sw_sum     = sw_total_r + step;
  assign inv_diff   = sw_inv_r - step;

  // decision for one word
  always_comb begin
    phase_nxt      = phase_r;
    target_nxt     = target_r;
    prev_tick_nxt  = prev_tick_r;
    hw_elapsed_nxt = hw_elapsed_r;
    sw_total_nxt   = sw_total_r;
    sw_inv_nxt     = sw_inv_r;
    sw_limit_nxt   = sw_limit_r;
    res.status        = gdt_pkg::ST_IGNORED;
    res.sleep_ms      = 6'd0;
    res.kick_watchdog = 1'b0;
    if (phase_r == gdt_pkg::PH_HALT) begin
      res.status = gdt_pkg::ST_IGNORED;
    end else if (in_data.kind == gdt_pkg::KIND_START) begin
      if (in_data.wait_ms == 32'd0) begin
        phase_nxt  = gdt_pkg::PH_IDLE;
        res.status = gdt_pkg::ST_DONE;
      end else begin
        target_nxt     = tgt_capped;
        prev_tick_nxt  = in_data.tick_now;
        hw_elapsed_nxt = 32'd0;
        sw_total_nxt   = 32'd0;
        sw_inv_nxt     = 32'hFFFF_FFFF;
        sw_limit_nxt   = tgt_capped * gdt_pkg::LIMIT_MULT + gdt_pkg::LIMIT_SLACK;
        phase_nxt      = gdt_pkg::PH_RUN;
        res.status     = gdt_pkg::ST_STARTED;
      end
    end else if (phase_r == gdt_pkg::PH_RUN) begin
      res.kick_watchdog = 1'b1;
      hw_elapsed_nxt    = hw_sum;
      prev_tick_nxt     = in_data.tick_now;
      if (hw_sum >= target_r && sw_total_r >= target_r) begin
        phase_nxt  = gdt_pkg::PH_IDLE;
        res.status = gdt_pkg::ST_DONE;
      end else if (sw_total_r > sw_limit_r) begin
        phase_nxt  = gdt_pkg::PH_HALT;
        res.status = gdt_pkg::ST_TIMING;
      end else begin
        sw_total_nxt = sw_sum;
        sw_inv_nxt   = inv_diff;
        if (sw_sum != ~inv_diff) begin
          phase_nxt  = gdt_pkg::PH_HALT;
          res.status = gdt_pkg::ST_GLITCH;
        end else begin
          res.status   = gdt_pkg::ST_SLEEP;
          res.sleep_ms = step[5:0];
        end
      end
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= gdt_pkg::PH_IDLE;
      target_r     <= 32'd0;
      prev_tick_r  <= 32'd0;
      hw_elapsed_r <= 32'd0;
      sw_total_r   <= 32'd0;
      sw_inv_r     <= 32'hFFFF_FFFF;
      sw_limit_r   <= 32'd0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      target_r     <= target_nxt;
      prev_tick_r  <= prev_tick_nxt;
      hw_elapsed_r <= hw_elapsed_nxt;
      sw_total_r   <= sw_total_nxt;
      sw_inv_r     <= sw_inv_nxt;
      sw_limit_r   <= sw_limit_nxt;
    end
  end

  // result register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= acc;
    end else begin
      out_valid_r <= acc;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (acc) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
      if (acc) begin
        skid_r <= res;
      end
    end else begin
      out_r <= res;
    end
  end

  // skid register only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without result word");

  // redundant totals agree whenever running
  a_twin_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gdt_pkg::PH_RUN |-> sw_total_r == ~sw_inv_r)
    else $error("software totals disagree while running");

  // a running target is nonzero and within the cap
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gdt_pkg::PH_RUN |-> (target_r != 32'd0 && target_r <= gdt_pkg::WAIT_CAP))
    else $error("running target out of range");

  // a halted timer ignores every word and keeps halting
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == gdt_pkg::PH_HALT) |->
      (res.status == gdt_pkg::ST_IGNORED && phase_nxt == gdt_pkg::PH_HALT))
    else $error("halted timer responded");

endmodule
